/* hw/rtl/kmds_pkg.sv */
// Shared types and constants of the key matrix debounce scanner.
package kmds_pkg;

    localparam int DEF_ROWS    = 4;
    localparam int DEF_COLUMNS = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int COL_FIELD_W = 2;
    localparam int ROW_FIELD_W = 4;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int KEY_MAP_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic             SCAN_EN_RESET  = 1'b1;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_ENABLE   = 2'd0,
        CFG_DEBOUNCE_TIME = 2'd1
    } t_cfg_reg;

    typedef enum logic {
        EV_PRESS   = 1'b0,
        EV_RELEASE = 1'b1
    } t_ev_kind;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] column_index;
        logic [ROW_FIELD_W-1:0] row_levels;
        logic [TIME_W-1:0]      time_ms;
    } t_in_item;

    typedef struct packed {
        logic                   event_kind;
        logic [1:0]             event_row;
        logic [COL_FIELD_W-1:0] event_column;
        logic [TIME_W-1:0]      event_time;
        logic [KEY_MAP_W-1:0]   key_map;
        logic                   last_event;
    } t_out_item;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] column;
        logic [TIME_W-1:0]      time_ms;
        logic [KEY_MAP_W-1:0]   base_map;
    } t_q_head;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hw/rtl/kmds_queue.sv */
// Short queue between the classifying front end and the event back end.
module kmds_queue #(
    parameter int W     = 8,
    parameter int DEPTH = kmds_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [W-1:0]        i_data,
    input  logic                i_pop,
    output logic [W-1:0]        o_data,
    output kmds_pkg::t_q_status o_status
);
    import kmds_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");

endmodule

/* hw/rtl/kmds_front.sv */
// Front end: configuration, per-key raw/debounced state and event classification.
module kmds_front #(
    parameter int ROWS    = kmds_pkg::DEF_ROWS,
    parameter int COLUMNS = kmds_pkg::DEF_COLUMNS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [kmds_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [kmds_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    input  logic                                        i_in_valid,
    input  kmds_pkg::t_in_item                          i_in_item,
    output logic                                        o_in_stall,
    input  kmds_pkg::t_q_status                         i_q_status,
    output logic                                        o_q_push,
    output logic [$bits(kmds_pkg::t_q_head)+2*ROWS-1:0] o_q_data
);
    import kmds_pkg::*;

    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_PAD = (ROWS > ROW_FIELD_W) ? ROWS : ROW_FIELD_W;

    logic                 r_scan_en;
    logic [DEB_W-1:0]     r_deb;
    logic [COLUMNS-1:0]   r_raw    [ROWS];
    logic [COLUMNS-1:0]   r_stable [ROWS];
    logic [TIME_W-1:0]    r_ct     [ROWS][COLUMNS];

    logic                 accept;
    logic                 active;
    logic                 in_range;
    logic [COL_W-1:0]     col_idx;
    logic [ROW_PAD-1:0]   rows_ext;
    logic [ROWS-1:0]      lvl;
    logic [ROWS-1:0]      chg;
    logic [ROWS-1:0]      ev;
    logic [TIME_W-1:0]    age [ROWS];
    logic [KEY_MAP_W-1:0] base_map;
    t_q_head              head;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = (4'(i_in_item.column_index) < 4'(COLUMNS));
    assign active     = accept && r_scan_en && in_range;
    assign col_idx    = COL_W'(i_in_item.column_index);
    assign rows_ext   = ROW_PAD'(i_in_item.row_levels);
    assign lvl        = rows_ext[ROWS-1:0];

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            chg[r] = (lvl[r] != r_raw[r][col_idx]);
            age[r] = i_in_item.time_ms - r_ct[r][col_idx];
            ev[r]  = (lvl[r] != r_stable[r][col_idx]) &&
                     (chg[r] ? (r_deb == '0) : (age[r] >= TIME_W'(r_deb)));
        end
    end

    always_comb begin
        base_map = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if (r * COLUMNS + c < KEY_MAP_W) begin
                    base_map[4'(r * COLUMNS + c)] = r_stable[r][c];
                end
            end
        end
    end

    assign head.column   = i_in_item.column_index;
    assign head.time_ms  = i_in_item.time_ms;
    assign head.base_map = base_map;
    assign o_q_data      = {head, lvl, ev};
    assign o_q_push      = active && (ev != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en <= SCAN_EN_RESET;
            r_deb     <= DEBOUNCE_RESET;
            for (int r = 0; r < ROWS; r++) begin
                r_raw[r]    <= '0;
                r_stable[r] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_SCAN_ENABLE:   r_scan_en <= i_cfg_data[0];
                    CFG_DEBOUNCE_TIME: r_deb     <= i_cfg_data[DEB_W-1:0];
                    default: ;
                endcase
            end
            if (active) begin
                for (int r = 0; r < ROWS; r++) begin
                    r_raw[r][col_idx] <= lvl[r];
                    if (ev[r]) begin
                        r_stable[r][col_idx] <= lvl[r];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            for (int r = 0; r < ROWS; r++) begin
                if (chg[r]) begin
                    r_ct[r][col_idx] <= i_in_item.time_ms;
                end
            end
        end
    end

    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_scan_en |-> !o_q_push)
        else $error("entry queued while scanning disabled");

endmodule

/* hw/rtl/kmds_back.sv */
// Back end: walks a queued sample's event rows and drives the registered result.
module kmds_back #(
    parameter int ROWS    = kmds_pkg::DEF_ROWS,
    parameter int COLUMNS = kmds_pkg::DEF_COLUMNS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  kmds_pkg::t_q_status                         i_q_status,
    input  logic [$bits(kmds_pkg::t_q_head)+2*ROWS-1:0] i_q_data,
    output logic                                        o_q_pop,
    output logic                                        o_out_valid,
    output kmds_pkg::t_out_item                         o_out_item,
    input  logic                                        i_out_stall
);
    import kmds_pkg::*;

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KIDX_W = $clog2(ROWS * COLUMNS + 1);

    t_q_head              q_head;
    logic [ROWS-1:0]      q_lvl;
    logic [ROWS-1:0]      q_mask;

    logic                   r_busy;
    logic [COL_FIELD_W-1:0] r_col;
    logic [TIME_W-1:0]      r_time;
    logic [ROWS-1:0]        r_lvl;
    logic [ROWS-1:0]        r_mask;
    logic [KEY_MAP_W-1:0]   r_map;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [ROW_W-1:0]     sel;
    logic [ROWS-1:0]      n_mask;
    logic [KIDX_W-1:0]    kidx;
    logic [7:0]           kidx8;
    logic [KEY_MAP_W-1:0] n_map;
    logic                 emit;

    assign {q_head, q_lvl, q_mask} = i_q_data;
    assign o_q_pop     = !r_busy && !i_q_status.empty;
    assign emit        = r_busy && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        sel = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (r_mask[r]) begin
                sel = ROW_W'(r);
            end
        end
    end

    assign n_mask = r_mask & (r_mask - 1'b1);
    assign kidx   = KIDX_W'(sel) * KIDX_W'(COLUMNS) + KIDX_W'(r_col);
    assign kidx8  = 8'(kidx);

    always_comb begin
        n_map = r_map;
        if (kidx8 < 8'(KEY_MAP_W)) begin
            n_map[kidx8[3:0]] = r_lvl[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (emit && n_mask == '0) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_col  <= q_head.column;
            r_time <= q_head.time_ms;
            r_lvl  <= q_lvl;
            r_mask <= q_mask;
            r_map  <= q_head.base_map;
        end else if (emit) begin
            r_mask <= n_mask;
            r_map  <= n_map;
        end
        if (emit) begin
            r_out.event_kind   <= r_lvl[sel] ? EV_PRESS : EV_RELEASE;
            r_out.event_row    <= 2'(sel);
            r_out.event_column <= r_col;
            r_out.event_time   <= r_time;
            r_out.key_map      <= n_map;
            r_out.last_event   <= (n_mask == '0);
        end
    end

    a_busy_has_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("busy with no rows left");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_mask == '0) |=> !r_busy)
        else $error("still busy after last event");

endmodule

/* hw/rtl/key_matrix_debounce_scanner_unit.sv */
// Top level of the key matrix scanner with per-key debounce.
// Events pass the queue, the back-end sample registers and the output register.
// Throughput: one sample per cycle while the 2-entry queue has room; the back end
// loads a sample and emits its events one at a time, unless the output stalls.
// Reset: synchronous; all keys released, scanning enabled, debounce 5 ms, queue empty.
module key_matrix_debounce_scanner_unit #(
    parameter int ROWS    = kmds_pkg::DEF_ROWS,
    parameter int COLUMNS = kmds_pkg::DEF_COLUMNS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kmds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kmds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  kmds_pkg::t_in_item              i_in_item,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output kmds_pkg::t_out_item             o_out_item,
    input  logic                            i_out_stall
);
    import kmds_pkg::*;

    localparam int QW = $bits(t_q_head) + 2 * ROWS;

    logic          q_push;
    logic          q_pop;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;
    t_q_status     q_status;

    assign o_cfg_ready = 1'b1;

    kmds_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_q_status  (q_status),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    kmds_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wdata),
        .i_pop    (q_pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    kmds_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
